// ===== rtl/core/mcsa_pkg.sv =====
// Package with the types, constants and helper functions of the mip chain size admission core.
`default_nettype none
package mcsa_pkg;

    localparam int DIM_W   = 16;
    localparam int MIPS_W  = 8;
    localparam int SRC_W   = 32;
    localparam int LVL_W   = 4;
    localparam int CHAIN_W = 5;
    localparam int PROD_W  = 32;
    localparam int RGBA_W  = 34;
    localparam int ASTC_W  = 32;
    localparam int WSET_W  = 35;
    localparam int PLIM_W  = 32;
    localparam int WLIM_W  = 34;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 34;
    localparam int ASTC_OUT_W = 29;
    localparam int RGBA_OUT_W = 31;
    localparam int STATUS_W = 2;

    localparam logic [LVL_W-1:0] LEVEL_CAP = 4'd15;
    localparam logic [PLIM_W-1:0] PAYLOAD_LIMIT_RESET = 32'd268435456;
    localparam logic [WLIM_W-1:0] WSET_LIMIT_RESET = 34'd201326592;
    localparam logic [ASTC_W-1:0] ASTC_FIELD_MAX = 32'h1FFF_FFFF;
    localparam logic [RGBA_W-1:0] RGBA_FIELD_MAX = 34'h0_7FFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WSET_LIMIT    = 2'd1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PAYLOAD   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_WORKSET   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEXEL,
        S_BLOCK,
        S_ACCUM,
        S_WSET,
        S_RESULT
    } t_state;

    // Full chain length: one plus the position of the leading one of the side.
    function automatic logic [CHAIN_W-1:0] chain_length(input logic [DIM_W-1:0] side);
        logic [CHAIN_W-1:0] n;
        n = CHAIN_W'(1);
        for (int i = 1; i < DIM_W; i++) begin
            if (side[i]) begin
                n = CHAIN_W'(i + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [DIM_W-1:0] blocks_of(input logic [DIM_W-1:0] side);
        logic [DIM_W:0] s;
        s = {1'b0, side} + (DIM_W+1)'(3);
        return DIM_W'(s[DIM_W:2]);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mip_chain_size_admission_core.sv =====
// Top level of the mip chain size admission core with its level sequencer and shared multiplier.
`default_nettype none
// An input word carries a texture's base width and height, its declared mip count and its
// source size; one result word follows with the clamped level count, the ASTC 4x4 and RGBA8
// chain totals and an admission status. One 16 by 16 multiplier is shared across the level
// loop, each level passing through the texel product, block product and accumulate states,
// and a rejected size skips the loop. The input stalls while an item is in work; a finished
// result waits in the output register while the next word may be accepted. Configuration
// writes are always ready.
module mip_chain_size_admission_core
    import mcsa_pkg::*;
#(
    parameter int MAX_DIM = 16384
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [DIM_W-1:0]      i_width_px,
    input  wire logic [DIM_W-1:0]      i_height_px,
    input  wire logic [MIPS_W-1:0]     i_requested_mips,
    input  wire logic [SRC_W-1:0]      i_source_bytes,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [LVL_W-1:0]           o_mip_levels,
    output logic [ASTC_OUT_W-1:0]      o_astc_total,
    output logic [RGBA_OUT_W-1:0]      o_rgba_total,
    output logic [STATUS_W-1:0]        o_status,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [DIM_W:0] MAX_SIDE = (DIM_W+1)'(MAX_DIM);

    t_state r_state, n_state;

    logic [PLIM_W-1:0] r_payload_limit;
    logic [WLIM_W-1:0] r_wset_limit;

    logic [DIM_W-1:0]  r_cw, r_ch;
    logic [SRC_W-1:0]  r_src;
    logic [LVL_W-1:0]  r_levels, r_lvl_cnt;
    logic              r_bad;
    logic [PROD_W-1:0] r_prod;
    logic [RGBA_W-1:0] r_rgba, r_base;
    logic [ASTC_W-1:0] r_astc;
    logic [WSET_W-1:0] r_wset;

    logic                  r_out_valid;
    logic [LVL_W-1:0]      r_out_levels;
    logic [ASTC_OUT_W-1:0] r_out_astc;
    logic [RGBA_OUT_W-1:0] r_out_rgba;
    logic [STATUS_W-1:0]   r_out_status;

    logic              in_accept, out_free, last_level;
    logic              bad_in;
    logic [DIM_W-1:0]  max_side, mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [CHAIN_W-1:0] chain;
    logic [LVL_W-1:0]  lvl_in;
    logic [STATUS_W-1:0] status_calc;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign last_level = (r_lvl_cnt + LVL_W'(1)) == r_levels;

    always_comb begin
        max_side = (i_width_px > i_height_px) ? i_width_px : i_height_px;
        chain    = chain_length(max_side);
        lvl_in   = LEVEL_CAP;
        if ({3'b0, chain} < i_requested_mips && chain < CHAIN_W'(LEVEL_CAP)) begin
            lvl_in = chain[LVL_W-1:0];
        end else if (i_requested_mips < MIPS_W'(LEVEL_CAP)) begin
            lvl_in = i_requested_mips[LVL_W-1:0];
        end
        bad_in = (i_width_px == '0) || (i_height_px == '0) ||
                 ({1'b0, i_width_px} > MAX_SIDE) || ({1'b0, i_height_px} > MAX_SIDE) ||
                 (i_requested_mips == '0);
    end

    // Shared multiplier: texel count first, then block count of the same level.
    always_comb begin
        if (r_state == S_BLOCK) begin
            mul_a = blocks_of(r_cw);
            mul_b = blocks_of(r_ch);
        end else begin
            mul_a = r_cw;
            mul_b = r_ch;
        end
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        if (r_astc == '0 || r_astc > r_payload_limit) begin
            status_calc = ST_PAYLOAD;
        end else if (r_wset > {{(WSET_W-WLIM_W){1'b0}}, r_wset_limit}) begin
            status_calc = ST_WORKSET;
        end else begin
            status_calc = ST_OK;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = bad_in ? S_RESULT : S_TEXEL;
                end
            end
            S_TEXEL: n_state = S_BLOCK;
            S_BLOCK: n_state = S_ACCUM;
            S_ACCUM: n_state = last_level ? S_WSET : S_TEXEL;
            S_WSET:  n_state = S_RESULT;
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall   = (r_state != S_IDLE);
        o_cfg_ready  = 1'b1;
        o_out_valid  = r_out_valid;
        o_mip_levels = r_out_levels;
        o_astc_total = r_out_astc;
        o_rgba_total = r_out_rgba;
        o_status     = r_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_valid     <= 1'b0;
            r_payload_limit <= PAYLOAD_LIMIT_RESET;
            r_wset_limit    <= WSET_LIMIT_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_PAYLOAD_LIMIT) begin
                    r_payload_limit <= i_cfg_data[PLIM_W-1:0];
                end else if (i_cfg_index == CFG_WSET_LIMIT) begin
                    r_wset_limit <= i_cfg_data[WLIM_W-1:0];
                end
            end
            if (r_state == S_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_cw      <= i_width_px;
                    r_ch      <= i_height_px;
                    r_src     <= i_source_bytes;
                    r_levels  <= lvl_in;
                    r_bad     <= bad_in;
                    r_lvl_cnt <= '0;
                    r_rgba    <= '0;
                    r_astc    <= '0;
                end
            end
            S_TEXEL: begin
                r_prod <= mul_p;
            end
            S_BLOCK: begin
                r_rgba <= r_rgba + {r_prod, 2'b00};
                if (r_lvl_cnt == '0) begin
                    r_base <= {r_prod, 2'b00};
                end
                r_prod <= mul_p;
            end
            S_ACCUM: begin
                r_astc    <= r_astc + {r_prod[ASTC_W-5:0], 4'b0000};
                r_cw      <= (r_cw[DIM_W-1:1] == '0) ? DIM_W'(1) : {1'b0, r_cw[DIM_W-1:1]};
                r_ch      <= (r_ch[DIM_W-1:1] == '0) ? DIM_W'(1) : {1'b0, r_ch[DIM_W-1:1]};
                r_lvl_cnt <= r_lvl_cnt + LVL_W'(1);
            end
            S_WSET: begin
                r_wset <= WSET_W'(r_src) + {2'b00, r_astc, 1'b0} + WSET_W'(r_base);
            end
            S_RESULT: begin
                if (out_free) begin
                    if (r_bad) begin
                        r_out_levels <= '0;
                        r_out_astc   <= '0;
                        r_out_rgba   <= '0;
                        r_out_status <= ST_BAD_SIZE;
                    end else begin
                        r_out_levels <= r_levels;
                        r_out_astc   <= (r_astc > ASTC_FIELD_MAX) ? ASTC_FIELD_MAX[ASTC_OUT_W-1:0]
                                                                  : r_astc[ASTC_OUT_W-1:0];
                        r_out_rgba   <= (r_rgba > RGBA_FIELD_MAX) ? RGBA_FIELD_MAX[RGBA_OUT_W-1:0]
                                                                  : r_rgba[RGBA_OUT_W-1:0];
                        r_out_status <= status_calc;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the mip chain size admission core with random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mcsa_pkg::*;

    localparam int MAX_SIDE = 16384;
    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_HOLD = 400;
    localparam int RANDOM_PER_PHASE = 275;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [LVL_W-1:0]      mip_levels;
        logic [ASTC_OUT_W-1:0] astc_total;
        logic [RGBA_OUT_W-1:0] rgba_total;
        logic [STATUS_W-1:0]   status;
    } t_chain_result;

    class admission_scoreboard;
        logic [PLIM_W-1:0] payload_limit;
        logic [WLIM_W-1:0] wset_limit;
        t_chain_result expected_q[$];
        int errors;
        int checked;
        int status_seen[4];

        function new();
            payload_limit = PAYLOAD_LIMIT_RESET;
            wset_limit = WSET_LIMIT_RESET;
            errors = 0;
            checked = 0;
            status_seen = '{0, 0, 0, 0};
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        function void write_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PAYLOAD_LIMIT: payload_limit = data[PLIM_W-1:0];
                CFG_WSET_LIMIT: wset_limit = data[WLIM_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_texture(logic [15:0] w, logic [15:0] h, logic [7:0] req,
                                   logic [31:0] src);
            t_chain_result e;
            logic [63:0] cw, ch, side, astc, rgba, base, wset;
            int n, lv;
            e = '0;
            e.status = ST_BAD_SIZE;
            if (w == 0 || h == 0 || w > MAX_SIDE || h > MAX_SIDE) begin
                expected_q.insert(expected_q.size(), e);
                return;
            end
            side = (w > h) ? 64'(w) : 64'(h);
            n = 1;
            while (side > 1) begin
                side = side >> 1;
                n++;
            end
            lv = (int'(req) < n) ? int'(req) : n;
            if (lv > 15) begin
                lv = 15;
            end
            if (lv == 0) begin
                expected_q.insert(expected_q.size(), e);
                return;
            end
            cw = 64'(w);
            ch = 64'(h);
            astc = 0;
            rgba = 0;
            for (int i = 0; i < lv; i++) begin
                astc += ((cw + 3) / 4) * ((ch + 3) / 4) * 16;
                rgba += cw * ch * 4;
                cw = (cw / 2 > 0) ? cw / 2 : 64'd1;
                ch = (ch / 2 > 0) ? ch / 2 : 64'd1;
            end
            base = 64'(w) * 64'(h) * 4;
            wset = 64'(src) + 2 * astc + base;
            if (astc == 0 || astc > 64'(payload_limit)) begin
                e.status = ST_PAYLOAD;
            end else if (wset > 64'(wset_limit)) begin
                e.status = ST_WORKSET;
            end else begin
                e.status = ST_OK;
            end
            e.mip_levels = LVL_W'(lv);
            e.astc_total = (astc > 64'h1FFF_FFFF) ? '1 : astc[ASTC_OUT_W-1:0];
            e.rgba_total = (rgba > 64'h7FFF_FFFF) ? '1 : rgba[RGBA_OUT_W-1:0];
            expected_q.insert(expected_q.size(), e);
        endfunction

        task check_result(t_chain_result got);
            t_chain_result e;
            checked++;
            status_seen[got.status]++;
            if (expected_q.size() == 0) begin
                report_mismatch("result word arrived with no texture pending");
                return;
            end
            e = expected_q.pop_front();
            if (got.mip_levels !== e.mip_levels) begin
                report_mismatch($sformatf("mip_levels %0d, expected %0d",
                                          got.mip_levels, e.mip_levels));
            end
            if (got.astc_total !== e.astc_total) begin
                report_mismatch($sformatf("astc_total %0d, expected %0d",
                                          got.astc_total, e.astc_total));
            end
            if (got.rgba_total !== e.rgba_total) begin
                report_mismatch($sformatf("rgba_total %0d, expected %0d",
                                          got.rgba_total, e.rgba_total));
            end
            if (got.status !== e.status) begin
                report_mismatch($sformatf("status %0d, expected %0d", got.status, e.status));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [DIM_W-1:0]      i_width_px;
    logic [DIM_W-1:0]      i_height_px;
    logic [MIPS_W-1:0]     i_requested_mips;
    logic [SRC_W-1:0]      i_source_bytes;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [LVL_W-1:0]      o_mip_levels;
    logic [ASTC_OUT_W-1:0] o_astc_total;
    logic [RGBA_OUT_W-1:0] o_rgba_total;
    logic [STATUS_W-1:0]   o_status;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    admission_scoreboard sb;
    bit no_idle;
    bit hold_long;
    int textures_sent;
    int cfg_writes;
    int idle_cycles;

    mip_chain_size_admission_core #(
        .MAX_DIM(MAX_SIDE)
    ) dut (.*);

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] log_rand(int bits);
        logic [63:0] mask;
        mask = (64'd1 << $urandom_range(0, bits)) - 64'd1;
        return 32'($urandom) & mask[31:0];
    endfunction

    function automatic logic [15:0] pick_side();
        int k;
        case ($urandom_range(0, 31))
            0: return '0;
            1: return 16'($urandom_range(MAX_SIDE + 1, 65535));
            2: return 16'(MAX_SIDE);
            3: return 16'($urandom);
            default: begin
                k = $urandom_range(0, 14);
                return 16'($urandom_range(1, 1 << k));
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_mips();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return 8'($urandom);
            2: return 8'd255;
            default: return 8'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic [31:0] pick_source();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'($urandom);
            default: return log_rand(32);
        endcase
    endfunction

    task automatic send_texture(input logic [15:0] w, input logic [15:0] h,
                                input logic [7:0] req, input logic [31:0] src);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_width_px = w;
        i_height_px = h;
        i_requested_mips = req;
        i_source_bytes = src;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_texture(w, h, req, src);
        textures_sent++;
    endtask

    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.write_limit(idx, data);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int hold;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_long) begin
                hold = LONG_HOLD;
                hold_long = 1'b0;
            end else begin
                hold = no_idle ? 0 : $urandom_range(0, 11);
            end
            @(negedge i_clk);
            if (hold > 0) begin
                i_out_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            sb.check_result('{o_mip_levels, o_astc_total, o_rgba_total, o_status});
        end
    end

    initial begin
        idle_cycles = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        logic [33:0] wset;
        sb = new();
        no_idle = 1'b0;
        hold_long = 1'b0;
        textures_sent = 0;
        cfg_writes = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_width_px = '0;
        i_height_px = '0;
        i_requested_mips = '0;
        i_source_bytes = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_PAYLOAD_LIMIT;
        i_cfg_data = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_texture(16'd1, 16'd1, 8'd1, 32'd0);
        send_texture(16'd16384, 16'd16384, 8'd255, 32'hFFFF_FFFF);
        send_texture(16'd8192, 16'd8192, 8'd255, 32'd0);
        send_texture(16'd0, 16'd16, 8'd4, 32'd100);
        send_texture(16'd16, 16'd0, 8'd4, 32'd100);
        send_texture(16'd16385, 16'd16, 8'd4, 32'd0);
        send_texture(16'd16, 16'd16385, 8'd4, 32'd0);
        send_texture(16'hFFFF, 16'hFFFF, 8'd255, 32'hFFFF_FFFF);
        send_texture(16'd3, 16'd3, 8'd0, 32'd0);
        send_texture(16'd1, 16'd16384, 8'd255, 32'd0);
        send_texture(16'd16384, 16'd1, 8'd255, 32'd0);
        send_texture(16'd7, 16'd5, 8'd2, 32'd5);
        send_texture(16'd5, 16'd9, 8'd100, 32'd0);
        send_texture(16'd16384, 16'd16384, 8'd15, 32'd0);
        send_texture(16'd2, 16'd3, 8'd2, 32'd0);
        send_texture(16'd1000, 16'd600, 8'd3, 32'hFFFF_FFFF);
        send_texture(16'd4096, 16'd4096, 8'd1, 32'd0);
        send_texture(16'hFFFF, 16'd1, 8'd1, 32'd0);
        drain();

        write_limit(CFG_PAYLOAD_LIMIT, 34'd4096);
        write_limit(CFG_WSET_LIMIT, 34'd24576);
        send_texture(16'd64, 16'd64, 8'd1, 32'd0);
        send_texture(16'd64, 16'd64, 8'd1, 32'd1);
        send_texture(16'd64, 16'd64, 8'd2, 32'd0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_limit(CFG_PAYLOAD_LIMIT, '0);
                    write_limit(CFG_WSET_LIMIT, '0);
                end
                1: begin
                    write_limit(CFG_PAYLOAD_LIMIT, {2'b11, 32'hFFFF_FFFF});
                    write_limit(CFG_WSET_LIMIT, '1);
                    write_limit(CFG_SPARE_A, 34'($urandom));
                end
                5: begin
                    write_limit(CFG_SPARE_B, '1);
                    write_limit(CFG_PAYLOAD_LIMIT, 34'(PAYLOAD_LIMIT_RESET));
                    write_limit(CFG_WSET_LIMIT, WSET_LIMIT_RESET);
                end
                default: begin
                    write_limit(CFG_PAYLOAD_LIMIT, {2'($urandom), log_rand(30)});
                    wset = 34'(log_rand(32)) << $urandom_range(0, 2);
                    write_limit(CFG_WSET_LIMIT, wset);
                end
            endcase
            hold_long = (ph == 2);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n % 40 == 0) begin
                    no_idle = ($urandom_range(0, 3) == 0);
                end
                send_texture(pick_side(), pick_side(), pick_mips(), pick_source());
            end
            no_idle = 1'b0;
            drain();
        end

        repeat (60) @(posedge i_clk);
        if (sb.expected_q.size() != 0) begin
            sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
        end
        $display("Run covered %0d textures, %0d result words and %0d limit writes.",
                 textures_sent, sb.checked, cfg_writes);
        $display("Status mix seen: ok %0d, bad size %0d, payload %0d, working set %0d.",
                 sb.status_seen[ST_OK], sb.status_seen[ST_BAD_SIZE],
                 sb.status_seen[ST_PAYLOAD], sb.status_seen[ST_WORKSET]);
        if (sb.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/mcsa_pkg.sv
rtl/core/mip_chain_size_admission_core.sv
bench/tb.sv
